// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/inv3_pkg.sv =====
`default_nettype none
package inv3_pkg;

   localparam int unsigned InW    = 16;
   localparam int unsigned OutW   = 32;
   localparam int unsigned CofW   = 33;
   localparam int unsigned DetW   = 49;
   localparam int unsigned MagCW  = 32;
   localparam int unsigned MagDW  = 48;
   localparam int unsigned FracSh = 24;
   localparam int unsigned NumW   = MagCW + FracSh;
   localparam int unsigned Lanes  = 9;
   localparam int unsigned DivStg = NumW;
   // stages ahead of the dividers: products, cofactors, determinant partials, det
   localparam int unsigned PreStg = 4;
   localparam int unsigned Lat    = PreStg + 1 + DivStg + 1;

   localparam logic [OutW-1:0] PosLimit = 32'h7FFF_FFFF;
   localparam logic [OutW-1:0] NegLimit = 32'h8000_0000;

   typedef logic signed [InW-1:0] elem_type;
   typedef logic signed [OutW-1:0] res_type;

   typedef struct packed {
      elem_type m_r0c0; elem_type m_r0c1; elem_type m_r0c2;
      elem_type m_r1c0; elem_type m_r1c1; elem_type m_r1c2;
      elem_type m_r2c0; elem_type m_r2c1; elem_type m_r2c2;
   } req_type;

   typedef struct packed {
      res_type inv_r0c0; res_type inv_r0c1; res_type inv_r0c2;
      res_type inv_r1c0; res_type inv_r1c1; res_type inv_r1c2;
      res_type inv_r2c0; res_type inv_r2c1; res_type inv_r2c2;
      logic    singular;
   } rsp_type;

   // control carried along beside a lane
   typedef struct packed {
      logic valid;
      logic neg;
   } lane_ctl_type;

endpackage
`default_nettype wire

// ===== src/inv3_if.sv =====
`default_nettype none
interface inv3_req_if import inv3_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface inv3_rsp_if import inv3_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/inv3_front.sv =====
`default_nettype none
module inv3_front import inv3_pkg::*; (
   input  wire                    clock,
   input  wire                    en,
   input  req_type                m_in,
   output logic signed [CofW-1:0] cof_out [Lanes],
   output logic signed [DetW-1:0] det_out
);

   logic signed [2*InW-1:0] p_ff [18];
   logic signed [2*InW-1:0] p_in [18];
   logic signed [InW-1:0]   c_ff [3];
   logic signed [CofW-1:0]  cof_ff [Lanes];
   logic signed [CofW-1:0]  cof_in [Lanes];
   logic signed [InW-1:0]   c2_ff [3];
   logic signed [CofW-1:0]  cof2_ff [Lanes];
   logic signed [DetW-1:0]  t_ff [3];
   logic signed [CofW-1:0]  cof3_ff [Lanes];
   logic signed [DetW-1:0]  det_ff;

   // two-by-two products, one per multiplier
   always_comb begin
      p_in[0]  = m_in.m_r1c1 * m_in.m_r2c2;  p_in[1]  = m_in.m_r1c2 * m_in.m_r2c1;
      p_in[2]  = m_in.m_r1c0 * m_in.m_r2c2;  p_in[3]  = m_in.m_r1c2 * m_in.m_r2c0;
      p_in[4]  = m_in.m_r1c0 * m_in.m_r2c1;  p_in[5]  = m_in.m_r1c1 * m_in.m_r2c0;
      p_in[6]  = m_in.m_r0c1 * m_in.m_r2c2;  p_in[7]  = m_in.m_r0c2 * m_in.m_r2c1;
      p_in[8]  = m_in.m_r0c0 * m_in.m_r2c2;  p_in[9]  = m_in.m_r0c2 * m_in.m_r2c0;
      p_in[10] = m_in.m_r0c0 * m_in.m_r2c1;  p_in[11] = m_in.m_r0c1 * m_in.m_r2c0;
      p_in[12] = m_in.m_r0c1 * m_in.m_r1c2;  p_in[13] = m_in.m_r0c2 * m_in.m_r1c1;
      p_in[14] = m_in.m_r0c0 * m_in.m_r1c2;  p_in[15] = m_in.m_r0c2 * m_in.m_r1c0;
      p_in[16] = m_in.m_r0c0 * m_in.m_r1c1;  p_in[17] = m_in.m_r0c1 * m_in.m_r1c0;
   end

   // adjugate entries, already transposed: lane r*3+c takes cofactor (c,r)
   always_comb begin
      cof_in[0] = CofW'(p_ff[0]) - CofW'(p_ff[1]);
      cof_in[3] = CofW'(p_ff[3]) - CofW'(p_ff[2]);
      cof_in[6] = CofW'(p_ff[4]) - CofW'(p_ff[5]);
      cof_in[1] = CofW'(p_ff[7]) - CofW'(p_ff[6]);
      cof_in[4] = CofW'(p_ff[8]) - CofW'(p_ff[9]);
      cof_in[7] = CofW'(p_ff[11]) - CofW'(p_ff[10]);
      cof_in[2] = CofW'(p_ff[12]) - CofW'(p_ff[13]);
      cof_in[5] = CofW'(p_ff[15]) - CofW'(p_ff[14]);
      cof_in[8] = CofW'(p_ff[16]) - CofW'(p_ff[17]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         c_ff   <= '{m_in.m_r0c0, m_in.m_r0c1, m_in.m_r0c2};
         cof_ff <= cof_in;
         c2_ff  <= c_ff;
         cof2_ff <= cof_ff;
         // first-row expansion: det = sum m0j * cof(0,j)
         t_ff[0] <= DetW'(c2_ff[0]) * DetW'(cof_ff[0]);
         t_ff[1] <= DetW'(c2_ff[1]) * DetW'(cof_ff[3]);
         t_ff[2] <= DetW'(c2_ff[2]) * DetW'(cof_ff[6]);
         cof3_ff <= cof2_ff;
         det_ff  <= t_ff[0] + t_ff[1] + t_ff[2];
      end
   end

   // det and cof3 sit in the same stage
   assign cof_out = cof3_ff;
   assign det_out = det_ff;

endmodule
`default_nettype wire

// ===== src/inv3_lane.sv =====
`default_nettype none
module inv3_lane import inv3_pkg::*; (
   input  wire                    clock,
   input  wire                    en,
   input  logic signed [CofW-1:0] adj,
   input  logic [MagDW-1:0]       dmag,
   input  logic                   dneg,
   output res_type                res
);

   // restoring divider, one quotient bit per stage
   logic [NumW-1:0]    num_ff [DivStg+1];
   logic [MagDW:0]     rem_ff [DivStg+1];
   logic [MagDW-1:0]   d_ff   [DivStg+1];
   logic [NumW-1:0]    q_ff   [DivStg+1];
   logic               neg_ff [DivStg+1];
   logic [MagCW-1:0]   amag;
   res_type            res_ff;
   logic [NumW-1:0]    q_fin;

   assign amag = adj[CofW-1] ? MagCW'(-adj) : MagCW'(adj);

   // rounding offset d/2 is added to the numerator, which still fits in NumW bits
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= {amag, FracSh'(0)} + NumW'(dmag >> 1);
         rem_ff[0] <= '0;
         d_ff[0]   <= dmag;
         q_ff[0]   <= '0;
         neg_ff[0] <= adj[CofW-1] ^ dneg;
      end
   end

   // quotient bits from the numerator come in msb first
   for (genvar s = 0; s < DivStg; s++) begin : g_stage
      logic [MagDW+1:0] trial;
      logic             take;
      assign trial = {rem_ff[s], num_ff[s][NumW-1]};
      assign take  = trial >= (MagDW+2)'(d_ff[s]);
      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s+1] <= num_ff[s] << 1;
            rem_ff[s+1] <= take ? (MagDW+1)'(trial - (MagDW+2)'(d_ff[s]))
                                : (MagDW+1)'(trial);
            d_ff[s+1]   <= d_ff[s];
            q_ff[s+1]   <= {q_ff[s][NumW-2:0], take};
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   // saturate and apply sign
   assign q_fin = q_ff[DivStg];
   always_ff @(posedge clock) begin
      if (en) begin
         if (neg_ff[DivStg]) begin
            res_ff <= (q_fin > NumW'(NegLimit)) ? NegLimit : -OutW'(q_fin);
         end else begin
            res_ff <= (q_fin > NumW'(PosLimit)) ? PosLimit : OutW'(q_fin);
         end
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// ===== src/invert_3x3_matrix.sv =====
`default_nettype none
// 3x3 matrix inverse by the adjugate. Takes one Q8.8 matrix per cycle while
// the pipeline is not stalled and returns nine Q16.16 entries, rounded to
// nearest (ties away from zero) and saturated, with a singular flag set and
// all entries zero when the determinant is zero. A result passes through a
// product stage, three cofactor and determinant stages, a lane input
// register, a 56-stage one-bit-per-stage divider in each of nine lanes, a
// sign and saturate register and the output register. When the result is not
// taken, one more result goes into a skid register and then the whole
// pipeline stalls; input ready comes from the skid valid register and reset,
// so a full stream with a ready receiver runs at one item a cycle.
`include "assert_macros.svh"
module invert_3x3_matrix import inv3_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   inv3_req_if.sink   req,
   inv3_rsp_if.source rsp
);

   logic                   en;
   logic signed [CofW-1:0] cof [Lanes];
   logic signed [DetW-1:0] det;
   logic [MagDW-1:0]       dmag;
   logic                   zero_in;
   res_type                lane_res [Lanes];
   logic [Lat-1:0]         vld_ff;
   logic [DivStg+1:0]      zero_ff;
   rsp_type                merge_in;
   rsp_type                out_ff;
   logic                   out_vld_ff;
   rsp_type                skid_ff;
   logic                   skid_vld_ff;

   // whole pipeline stalls only while the skid register holds a transfer
   assign en = !skid_vld_ff;
   assign req.ready = en && !reset;

   inv3_front u_front (
      .clock(clock), .en(en), .m_in(req.data), .cof_out(cof), .det_out(det)
   );

   assign dmag    = det[DetW-1] ? MagDW'(-det) : MagDW'(det);
   assign zero_in = (det == '0);

   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      inv3_lane u_lane (
         .clock(clock), .en(en), .adj(cof[l]),
         .dmag(zero_in ? MagDW'(1) : dmag), .dneg(det[DetW-1]), .res(lane_res[l])
      );
   end

   // valid and singular tracks
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Lat-2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= {zero_ff[DivStg:0], zero_in};
      end
   end

   // merge lanes
   always_comb begin
      merge_in.singular = zero_ff[DivStg+1];
      merge_in.inv_r0c0 = zero_ff[DivStg+1] ? '0 : lane_res[0];
      merge_in.inv_r0c1 = zero_ff[DivStg+1] ? '0 : lane_res[1];
      merge_in.inv_r0c2 = zero_ff[DivStg+1] ? '0 : lane_res[2];
      merge_in.inv_r1c0 = zero_ff[DivStg+1] ? '0 : lane_res[3];
      merge_in.inv_r1c1 = zero_ff[DivStg+1] ? '0 : lane_res[4];
      merge_in.inv_r1c2 = zero_ff[DivStg+1] ? '0 : lane_res[5];
      merge_in.inv_r2c0 = zero_ff[DivStg+1] ? '0 : lane_res[6];
      merge_in.inv_r2c1 = zero_ff[DivStg+1] ? '0 : lane_res[7];
      merge_in.inv_r2c2 = zero_ff[DivStg+1] ? '0 : lane_res[8];
   end

   // output register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp.ready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= vld_ff[Lat-1];
         end
      end else if (en) begin
         skid_vld_ff <= vld_ff[Lat-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp.ready) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else begin
            out_ff <= merge_in;
         end
      end else if (en) begin
         skid_ff <= merge_in;
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;

   `ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
   `ASSERT_IMPLY(a_rdy, clock, reset, !rsp.valid, req.ready)
   `ASSERT_IMPLY(a_sing, clock, reset, rsp.valid && rsp.data.singular,
                 rsp.data.inv_r0c0 == '0 && rsp.data.inv_r2c2 == '0)

endmodule
`default_nettype wire
